@@ design/bba_pkg.sv @@
`timescale 1ns / 1ps

package bba_pkg;

   // Store geometry
   localparam int GROUPS     = 8;
   localparam int BPG_MAX    = 1024;
   localparam int REPORT_MAX = 16;
   localparam int STORE_MAX  = GROUPS * BPG_MAX;

   // Bitmap memory organization: one row holds WORD_W block bits
   localparam int WORD_W = 32;
   localparam int BIT_W  = $clog2(WORD_W);
   localparam int POS_W  = $clog2(BPG_MAX);
   localparam int WSEL_W = POS_W - BIT_W;
   localparam int GRP_W  = $clog2(GROUPS);
   localparam int ROW_AW = GRP_W + WSEL_W;
   localparam int ROWS   = STORE_MAX / WORD_W;

   // Field and register widths
   localparam int FUNC_W     = 2;
   localparam int BLK_W      = 14;
   localparam int WANT_W     = 5;
   localparam int STATUS_W   = 2;
   localparam int BPG_W      = 11;
   localparam int GCNT_W     = 4;
   localparam int CSR_DATA_W = 11;
   localparam int CSR_IDX_W  = 1;
   localparam int GFREE_W    = 11;
   localparam int SFREE_W    = 14;
   localparam int REM_W      = 13;
   localparam int LIM_W      = BPG_W + GCNT_W;

   typedef logic [FUNC_W-1:0]    func_type;
   typedef logic [STATUS_W-1:0]  status_type;
   typedef logic [CSR_IDX_W-1:0] csr_idx_type;

   localparam func_type FUNC_SEARCH = 2'd0;
   localparam func_type FUNC_ALLOC  = 2'd1;
   localparam func_type FUNC_FREE   = 2'd2;
   localparam func_type FUNC_RSVD   = 2'd3;

   localparam status_type ST_OK    = 2'd0;
   localparam status_type ST_NONE  = 2'd1;
   localparam status_type ST_RANGE = 2'd2;

   localparam csr_idx_type CSR_BPG    = 1'd0;
   localparam csr_idx_type CSR_GROUPS = 1'd1;

   // Controller to datapath
   typedef struct packed {
      logic load;
      logic start;
      logic div_step;
      logic mem_rd;
      logic mem_wr;
      logic word_load;
      logic take_bit;
      logic next_word;
      logic push_final;
      logic push_resp;
   } cmd_type;

   // Datapath to controller
   typedef struct packed {
      logic is_search;
      logic bad;
      logic div_done;
      logic word_empty;
      logic last_word;
      logic last_group;
      logic reached_want;
      logic out_free;
      logic pend_valid;
   } sts_type;

endpackage

@@ design/bba_if.sv @@
`timescale 1ns / 1ps

interface bba_req_if;
   logic                           valid;
   logic                           ready;
   logic [bba_pkg::FUNC_W-1:0]     func;
   logic [bba_pkg::BLK_W-1:0]      block_number;
   logic [bba_pkg::WANT_W-1:0]     wanted_count;

   modport source (output valid, func, block_number, wanted_count, input ready);
   modport sink   (input valid, func, block_number, wanted_count, output ready);
endinterface

interface bba_rsp_if;
   logic                           valid;
   logic                           ready;
   logic [bba_pkg::BLK_W-1:0]      found_block;
   logic [bba_pkg::STATUS_W-1:0]   status;
   logic                           last;
   logic [bba_pkg::SFREE_W-1:0]    total_free;

   modport source (output valid, found_block, status, last, total_free, input ready);
   modport sink   (input valid, found_block, status, last, total_free, output ready);
endinterface

@@ design/bba_ctrl.sv @@
`timescale 1ns / 1ps

module bba_ctrl (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   output bba_pkg::cmd_type cmd,
   input  bba_pkg::sts_type sts
);

   localparam logic [3:0] S_IDLE   = 4'd0;
   localparam logic [3:0] S_CHECK  = 4'd1;
   localparam logic [3:0] S_DIV    = 4'd2;
   localparam logic [3:0] S_MREAD  = 4'd3;
   localparam logic [3:0] S_MWRITE = 4'd4;
   localparam logic [3:0] S_RESP   = 4'd5;
   localparam logic [3:0] S_SREAD  = 4'd6;
   localparam logic [3:0] S_SWORD  = 4'd7;
   localparam logic [3:0] S_SBITS  = 4'd8;
   localparam logic [3:0] S_SEND   = 4'd9;

   logic [3:0] state_ff;
   logic [3:0] state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_ready = 1'b0;
      case (state_ff)
         S_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = S_CHECK;
            end
         end
         S_CHECK: begin
            cmd.start = 1'b1;
            if (sts.is_search) begin
               state_in = S_SREAD;
            end else if (sts.bad) begin
               state_in = S_RESP;
            end else begin
               state_in = S_DIV;
            end
         end
         S_DIV: begin
            if (sts.div_done) begin
               state_in = S_MREAD;
            end else begin
               cmd.div_step = 1'b1;
            end
         end
         S_MREAD: begin
            cmd.mem_rd = 1'b1;
            state_in   = S_MWRITE;
         end
         S_MWRITE: begin
            cmd.mem_wr = 1'b1;
            state_in   = S_RESP;
         end
         S_RESP: begin
            if (sts.out_free) begin
               cmd.push_resp = 1'b1;
               state_in      = S_IDLE;
            end
         end
         S_SREAD: begin
            cmd.mem_rd = 1'b1;
            state_in   = S_SWORD;
         end
         S_SWORD: begin
            cmd.word_load = 1'b1;
            state_in      = S_SBITS;
         end
         S_SBITS: begin
            if (sts.word_empty) begin
               if (sts.last_word && sts.last_group) begin
                  state_in = S_SEND;
               end else begin
                  cmd.next_word = 1'b1;
                  state_in      = S_SREAD;
               end
            end else if (!sts.pend_valid || sts.out_free) begin
               cmd.take_bit = 1'b1;
               if (sts.reached_want) begin
                  state_in = S_SEND;
               end
            end
         end
         S_SEND: begin
            if (sts.out_free) begin
               cmd.push_final = 1'b1;
               state_in       = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

endmodule

@@ design/bba_dpath.sv @@
`timescale 1ns / 1ps

module bba_dpath (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              csr_write_en,
   input  logic [bba_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [bba_pkg::CSR_DATA_W-1:0]    csr_data,
   input  logic [bba_pkg::FUNC_W-1:0]        in_func,
   input  logic [bba_pkg::BLK_W-1:0]         in_block_number,
   input  logic [bba_pkg::WANT_W-1:0]        in_wanted_count,
   input  logic                              out_ready,
   output logic                              out_valid,
   output logic [bba_pkg::BLK_W-1:0]         out_found_block,
   output logic [bba_pkg::STATUS_W-1:0]      out_status,
   output logic                              out_last,
   output logic [bba_pkg::SFREE_W-1:0]       out_total_free,
   input  bba_pkg::cmd_type                  cmd,
   output bba_pkg::sts_type                  sts
);

   // Configuration registers, kept as written
   logic [bba_pkg::BPG_W-1:0]   bpg_csr_ff;
   logic [bba_pkg::GCNT_W-1:0]  grp_csr_ff;
   logic [bba_pkg::BPG_W-1:0]   bpg_eff;
   logic [bba_pkg::GCNT_W-1:0]  ng_eff;
   logic [bba_pkg::LIM_W-1:0]   limit;

   // Latched item
   bba_pkg::func_type           func_ff;
   logic [bba_pkg::BLK_W-1:0]   num_ff;
   logic [bba_pkg::WANT_W-1:0]  want_ff;
   logic [bba_pkg::WANT_W-1:0]  want_in;
   logic                        bad_ff;
   logic                        check_bad;

   // Walk position
   logic [bba_pkg::GRP_W-1:0]   g_ff;
   logic [bba_pkg::WSEL_W-1:0]  w_ff;
   logic [bba_pkg::REM_W-1:0]   rem_ff;
   logic [bba_pkg::BLK_W-1:0]   base_ff;
   logic [bba_pkg::BLK_W-1:0]   gbase_ff;
   logic [bba_pkg::BPG_W-1:0]   wsum;
   logic [bba_pkg::WSEL_W:0]    nwords;
   logic [bba_pkg::BPG_W-1:0]   lim;
   logic                        last_word;
   logic                        last_group;

   // Word scan
   logic [bba_pkg::WORD_W-1:0]  cur_ff;
   logic [bba_pkg::WORD_W-1:0]  mask;
   logic [bba_pkg::WORD_W-1:0]  low_onehot;
   logic [bba_pkg::BIT_W-1:0]   idx;
   logic [bba_pkg::BLK_W-1:0]   found;
   logic [bba_pkg::WANT_W-1:0]  n_ff;
   logic [bba_pkg::BLK_W-1:0]   pend_ff;
   logic                        pend_valid_ff;

   // Bitmap memory
   logic [bba_pkg::WORD_W-1:0]  mem [bba_pkg::ROWS];
   logic [bba_pkg::ROWS-1:0]    row_valid_ff;
   logic [bba_pkg::WORD_W-1:0]  rdata_ff;
   logic                        rvalid_ff;
   logic [bba_pkg::ROW_AW-1:0]  row_addr;
   logic [bba_pkg::WORD_W-1:0]  row_word;
   logic [bba_pkg::WORD_W-1:0]  bit_mask;
   logic [bba_pkg::WORD_W-1:0]  new_word;
   logic                        is_alloc;

   // Free counts
   logic [bba_pkg::GFREE_W-1:0] group_free_ff [bba_pkg::GROUPS];
   logic [bba_pkg::SFREE_W-1:0] store_free_ff;

   // Result register
   logic                        push;
   logic [bba_pkg::BLK_W-1:0]   push_found;
   bba_pkg::status_type         push_status;
   logic                        push_last;
   logic                        out_valid_ff;
   logic [bba_pkg::BLK_W-1:0]   out_found_ff;
   bba_pkg::status_type         out_status_ff;
   logic                        out_last_ff;
   logic [bba_pkg::SFREE_W-1:0] out_total_ff;
   logic                        out_free;

   always_ff @(posedge clock) begin
      if (reset) begin
         bpg_csr_ff <= bba_pkg::BPG_W'(bba_pkg::BPG_MAX);
         grp_csr_ff <= bba_pkg::GCNT_W'(bba_pkg::GROUPS);
      end else if (csr_write_en) begin
         case (csr_index)
            bba_pkg::CSR_BPG:    bpg_csr_ff <= csr_data;
            bba_pkg::CSR_GROUPS: grp_csr_ff <= csr_data[bba_pkg::GCNT_W-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      if (bpg_csr_ff == '0) begin
         bpg_eff = bba_pkg::BPG_W'(1);
      end else if (bpg_csr_ff > bba_pkg::BPG_W'(bba_pkg::BPG_MAX)) begin
         bpg_eff = bba_pkg::BPG_W'(bba_pkg::BPG_MAX);
      end else begin
         bpg_eff = bpg_csr_ff;
      end
      if (grp_csr_ff == '0) begin
         ng_eff = bba_pkg::GCNT_W'(1);
      end else if (grp_csr_ff > bba_pkg::GCNT_W'(bba_pkg::GROUPS)) begin
         ng_eff = bba_pkg::GCNT_W'(bba_pkg::GROUPS);
      end else begin
         ng_eff = grp_csr_ff;
      end
   end

   assign limit = bba_pkg::LIM_W'(bpg_eff) * bba_pkg::LIM_W'(ng_eff);

   always_comb begin
      if (in_wanted_count == '0) begin
         want_in = bba_pkg::WANT_W'(1);
      end else if (in_wanted_count > bba_pkg::WANT_W'(bba_pkg::REPORT_MAX)) begin
         want_in = bba_pkg::WANT_W'(bba_pkg::REPORT_MAX);
      end else begin
         want_in = in_wanted_count;
      end
   end

   assign check_bad = (func_ff == bba_pkg::FUNC_RSVD) || (num_ff == '0) ||
                      (bba_pkg::LIM_W'(num_ff) > limit);

   // Geometry of the current group
   assign wsum       = bpg_eff + bba_pkg::BPG_W'(bba_pkg::WORD_W - 1);
   assign nwords     = wsum[bba_pkg::BIT_W +: (bba_pkg::WSEL_W+1)];
   assign last_word  = ((bba_pkg::WSEL_W+1)'(w_ff) + (bba_pkg::WSEL_W+1)'(1)) == nwords;
   assign last_group = (bba_pkg::GCNT_W'(g_ff) + bba_pkg::GCNT_W'(1)) == ng_eff;
   assign lim        = bpg_eff - bba_pkg::BPG_W'({w_ff, bba_pkg::BIT_W'(0)});

   always_comb begin
      for (int i = 0; i < bba_pkg::WORD_W; i++) begin
         mask[i] = bba_pkg::BPG_W'(i) < lim;
      end
   end

   // Lowest clear block of the current word
   assign low_onehot = cur_ff & (~cur_ff + bba_pkg::WORD_W'(1));

   always_comb begin
      idx = '0;
      for (int i = 0; i < bba_pkg::WORD_W; i++) begin
         if (low_onehot[i]) begin
            idx = idx | bba_pkg::BIT_W'(i);
         end
      end
   end

   assign found = base_ff + bba_pkg::BLK_W'(idx);

   // Memory addressing and read-modify-write
   assign row_addr = (func_ff == bba_pkg::FUNC_SEARCH) ? {g_ff, w_ff}
                                                       : {g_ff, rem_ff[bba_pkg::POS_W-1:bba_pkg::BIT_W]};
   assign row_word = rvalid_ff ? rdata_ff : '0;
   assign bit_mask = bba_pkg::WORD_W'(1) << rem_ff[bba_pkg::BIT_W-1:0];
   assign is_alloc = func_ff == bba_pkg::FUNC_ALLOC;
   assign new_word = is_alloc ? (row_word | bit_mask) : (row_word & ~bit_mask);

   always_ff @(posedge clock) begin
      if (cmd.mem_wr) begin
         mem[row_addr] <= new_word;
      end
      if (cmd.mem_rd) begin
         rdata_ff  <= mem[row_addr];
         rvalid_ff <= row_valid_ff[row_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         row_valid_ff <= '0;
      end else if (cmd.mem_wr) begin
         row_valid_ff[row_addr] <= 1'b1;
      end
   end

   // Item and walk registers
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         func_ff <= in_func;
         num_ff  <= in_block_number;
         want_ff <= want_in;
      end
      if (cmd.start) begin
         bad_ff   <= check_bad;
         rem_ff   <= bba_pkg::REM_W'(num_ff - bba_pkg::BLK_W'(1));
         g_ff     <= '0;
         w_ff     <= '0;
         base_ff  <= bba_pkg::BLK_W'(1);
         gbase_ff <= bba_pkg::BLK_W'(1);
         n_ff     <= '0;
      end
      if (cmd.div_step) begin
         rem_ff <= rem_ff - bba_pkg::REM_W'(bpg_eff);
         g_ff   <= g_ff + bba_pkg::GRP_W'(1);
      end
      if (cmd.word_load) begin
         cur_ff <= ~row_word & mask;
      end
      if (cmd.take_bit) begin
         cur_ff  <= cur_ff & ~low_onehot;
         pend_ff <= found;
         n_ff    <= n_ff + bba_pkg::WANT_W'(1);
      end
      if (cmd.next_word) begin
         if (last_word) begin
            g_ff     <= g_ff + bba_pkg::GRP_W'(1);
            w_ff     <= '0;
            gbase_ff <= gbase_ff + bba_pkg::BLK_W'(bpg_eff);
            base_ff  <= gbase_ff + bba_pkg::BLK_W'(bpg_eff);
         end else begin
            w_ff    <= w_ff + bba_pkg::WSEL_W'(1);
            base_ff <= base_ff + bba_pkg::BLK_W'(bba_pkg::WORD_W);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pend_valid_ff <= 1'b0;
      end else if (cmd.start) begin
         pend_valid_ff <= 1'b0;
      end else if (cmd.take_bit) begin
         pend_valid_ff <= 1'b1;
      end
   end

   // Free counts, saturating at both ends
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < bba_pkg::GROUPS; i++) begin
            group_free_ff[i] <= bba_pkg::GFREE_W'(bba_pkg::BPG_MAX);
         end
         store_free_ff <= bba_pkg::SFREE_W'(bba_pkg::STORE_MAX);
      end else if (cmd.mem_wr) begin
         if (is_alloc) begin
            if (group_free_ff[g_ff] != '0) begin
               group_free_ff[g_ff] <= group_free_ff[g_ff] - bba_pkg::GFREE_W'(1);
            end
            if (store_free_ff != '0) begin
               store_free_ff <= store_free_ff - bba_pkg::SFREE_W'(1);
            end
         end else begin
            if (group_free_ff[g_ff] != bba_pkg::GFREE_W'(bba_pkg::BPG_MAX)) begin
               group_free_ff[g_ff] <= group_free_ff[g_ff] + bba_pkg::GFREE_W'(1);
            end
            if (store_free_ff != bba_pkg::SFREE_W'(bba_pkg::STORE_MAX)) begin
               store_free_ff <= store_free_ff + bba_pkg::SFREE_W'(1);
            end
         end
      end
   end

   // Result selection
   always_comb begin
      push        = 1'b0;
      push_found  = '0;
      push_status = bba_pkg::ST_OK;
      push_last   = 1'b0;
      if (cmd.take_bit && pend_valid_ff) begin
         push       = 1'b1;
         push_found = pend_ff;
      end
      if (cmd.push_final) begin
         push      = 1'b1;
         push_last = 1'b1;
         if (pend_valid_ff) begin
            push_found = pend_ff;
         end else begin
            push_status = bba_pkg::ST_NONE;
         end
      end
      if (cmd.push_resp) begin
         push        = 1'b1;
         push_last   = 1'b1;
         push_status = bad_ff ? bba_pkg::ST_RANGE : bba_pkg::ST_OK;
      end
   end

   assign out_free = !out_valid_ff || out_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (push) begin
         out_valid_ff <= 1'b1;
      end else if (out_ready) begin
         out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         out_found_ff  <= push_found;
         out_status_ff <= push_status;
         out_last_ff   <= push_last;
         out_total_ff  <= store_free_ff;
      end
   end

   assign out_valid       = out_valid_ff;
   assign out_found_block = out_found_ff;
   assign out_status      = out_status_ff;
   assign out_last        = out_last_ff;
   assign out_total_free  = out_total_ff;

   assign sts.is_search    = func_ff == bba_pkg::FUNC_SEARCH;
   assign sts.bad          = check_bad;
   assign sts.div_done     = rem_ff < bba_pkg::REM_W'(bpg_eff);
   assign sts.word_empty   = cur_ff == '0;
   assign sts.last_word    = last_word;
   assign sts.last_group   = last_group;
   assign sts.reached_want = (n_ff + bba_pkg::WANT_W'(1)) == want_ff;
   assign sts.out_free     = out_free;
   assign sts.pend_valid   = pend_valid_ff;

endmodule

@@ design/block_bitmap_allocator_unit.sv @@
`timescale 1ns / 1ps

// Channel   Dir  Beat contents                                 Accepted when
// req_chan  in   func, block_number, wanted_count              valid & ready
// rsp_chan  out  found_block, status, last, total_free         valid & ready
// csr_*     in   csr_index, csr_data (blocks_per_group, groups) csr_write_en
//
// One item at a time. Allocate and free: one subtract of blocks_per_group per
// cycle for the group (up to 7), then a row read and write; out of range goes
// straight to the response. Search: a row read and a scan per 32-bit row, taking
// one reported block at a time, over up to the 256 rows of the store.
// Reset is synchronous and clears a written flag per row; no clearing pass.
// A stalled rsp beat holds the walk; the next item is taken while a final beat waits.

module block_bitmap_allocator_unit (
   input  logic                            clock,
   input  logic                            reset,
   bba_req_if.sink                         req_chan,
   bba_rsp_if.source                       rsp_chan,
   input  logic                            csr_write_en,
   input  logic [bba_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [bba_pkg::CSR_DATA_W-1:0]  csr_data
);

   bba_pkg::cmd_type cmd;
   bba_pkg::sts_type sts;

   // Sequencer: walks an item through check, group split, row access, scan
   bba_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_ready (req_chan.ready),
      .cmd       (cmd),
      .sts       (sts)
   );

   // Bitmap rows, free counts, scan position and the result register
   bba_dpath u_dpath (
      .clock           (clock),
      .reset           (reset),
      .csr_write_en    (csr_write_en),
      .csr_index       (csr_index),
      .csr_data        (csr_data),
      .in_func         (req_chan.func),
      .in_block_number (req_chan.block_number),
      .in_wanted_count (req_chan.wanted_count),
      .out_ready       (rsp_chan.ready),
      .out_valid       (rsp_chan.valid),
      .out_found_block (rsp_chan.found_block),
      .out_status      (rsp_chan.status),
      .out_last        (rsp_chan.last),
      .out_total_free  (rsp_chan.total_free),
      .cmd             (cmd),
      .sts             (sts)
   );

endmodule

@@ design/bba_checker.sv @@
`timescale 1ns / 1ps

module bba_checker (
   input logic                           clock,
   input logic                           reset,
   input logic                           req_valid,
   input logic                           req_ready,
   input logic                           rsp_valid,
   input logic                           rsp_ready,
   input logic [bba_pkg::BLK_W-1:0]      rsp_found_block,
   input logic [bba_pkg::STATUS_W-1:0]   rsp_status,
   input logic                           rsp_last
);

   logic       req_beat;
   logic       end_beat;
   logic [1:0] open_ff;

   assign req_beat = req_valid && req_ready;
   assign end_beat = rsp_valid && rsp_ready && rsp_last;

   // Count items accepted whose final beat has not gone out yet
   always_ff @(posedge clock) begin
      if (reset) begin
         open_ff <= '0;
      end else begin
         open_ff <= open_ff + 2'(req_beat) - 2'(end_beat);
      end
   end

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("rsp beat dropped while stalled");

   a_no_stray_rsp: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> open_ff != 2'd0)
      else $error("rsp beat without an open item");

   a_one_in_work: assert property (@(posedge clock) disable iff (reset)
      req_beat |-> open_ff <= 2'd1)
      else $error("item taken while another is still in work");

   a_error_final: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status != bba_pkg::ST_OK |-> rsp_last && rsp_found_block == '0)
      else $error("failed beat carries a block or is not final");

endmodule

bind block_bitmap_allocator_unit bba_checker u_bba_checker (
   .clock           (clock),
   .reset           (reset),
   .req_valid       (req_chan.valid),
   .req_ready       (req_chan.ready),
   .rsp_valid       (rsp_chan.valid),
   .rsp_ready       (rsp_chan.ready),
   .rsp_found_block (rsp_chan.found_block),
   .rsp_status      (rsp_chan.status),
   .rsp_last        (rsp_chan.last)
);
